// ===== src/cbl_pkg.sv =====
// ----------------------------------------------------------------------------
// cbl_pkg
// Shared types and constants for the comment blanker: byte codes and the
// record format that passes from the lexer front end to the output stage.
// ----------------------------------------------------------------------------
package cbl_pkg;

    // Character codes
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    // Record queue geometry
    localparam int QAW    = 2;
    localparam int QDEPTH = 1 << QAW;

    // One classified item: one or two output bytes
    typedef struct packed {
        logic       two_res;   // item gives two bytes
        logic       last;      // item closes the source
        logic [7:0] b0;        // first byte
        logic [7:0] b1;        // second byte, valid when two_res
    } t_rec;

endpackage

// ===== src/cbl_if.sv =====
// ----------------------------------------------------------------------------
// cbl_in_if / cbl_out_if
// Valid/ready channels for source bytes in and blanked bytes out.
// ----------------------------------------------------------------------------
interface cbl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       source_end;

    modport source (output valid, output in_byte, output source_end, input ready);
    modport sink   (input valid, input in_byte, input source_end, output ready);
endinterface

interface cbl_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       stream_done;

    modport source (output valid, output out_byte, output run_last,
                    output stream_done, input ready);
    modport sink   (input valid, input out_byte, input run_last,
                    input stream_done, output ready);
endinterface

// ===== src/cbl_front.sv =====
// ----------------------------------------------------------------------------
// cbl_front
// Lexer front end: accepts source bytes, tracks code/comment/literal state
// and pushes a record of the one or two output bytes each item causes.
// ----------------------------------------------------------------------------
module cbl_front
    import cbl_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    cbl_in_if.sink         i_in,
    input  logic           i_full,
    output logic           o_push,
    output t_rec           o_rec
);

    typedef enum logic [1:0] {
        M_CODE  = 2'd0,
        M_LINE  = 2'd1,
        M_BLOCK = 2'd2,
        M_QUOTE = 2'd3
    } t_lex_mode;

    t_lex_mode r_mode, n_mode;
    logic      r_qsingle, n_qsingle;
    logic      r_esc, n_esc;
    logic      r_slash, n_slash;
    logic      r_star, n_star;

    logic       accept;
    logic [7:0] c;
    logic       last;
    logic       emit;
    t_rec       rec;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;
    assign c          = i_in.in_byte;
    assign last       = i_in.source_end;

    // Next state and output record for the current byte
    always_comb begin
        n_mode      = r_mode;
        n_qsingle   = r_qsingle;
        n_esc       = r_esc;
        n_slash     = r_slash;
        n_star      = r_star;
        emit        = 1'b1;
        rec.two_res = 1'b0;
        rec.last    = last;
        rec.b0      = c;
        rec.b1      = c;

        unique case (r_mode)
            M_CODE: begin
                if (r_slash) begin
                    n_slash = 1'b0;
                    if (c == CH_SLASH) begin
                        rec.two_res = 1'b1;
                        rec.b0      = CH_SPACE;
                        rec.b1      = CH_SPACE;
                        n_mode      = M_LINE;
                    end else if (c == CH_STAR) begin
                        rec.two_res = 1'b1;
                        rec.b0      = CH_SPACE;
                        rec.b1      = CH_SPACE;
                        n_mode      = M_BLOCK;
                        n_star      = 1'b0;
                    end else begin
                        // held slash was plain code
                        rec.two_res = 1'b1;
                        rec.b0      = CH_SLASH;
                        rec.b1      = c;
                        if (c == CH_DQUOTE || c == CH_SQUOTE) begin
                            n_mode    = M_QUOTE;
                            n_qsingle = (c == CH_SQUOTE);
                            n_esc     = 1'b0;
                        end
                    end
                end else if (c == CH_SLASH) begin
                    // hold unless source ends here
                    if (!last) begin
                        emit    = 1'b0;
                        n_slash = 1'b1;
                    end
                end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
                    n_mode    = M_QUOTE;
                    n_qsingle = (c == CH_SQUOTE);
                    n_esc     = 1'b0;
                end
            end
            M_LINE: begin
                if (c == CH_NL) begin
                    n_mode = M_CODE;
                end else begin
                    rec.b0 = CH_SPACE;
                end
            end
            M_BLOCK: begin
                if (c == CH_NL) begin
                    n_star = 1'b0;
                end else begin
                    rec.b0 = CH_SPACE;
                    if (r_star && c == CH_SLASH) begin
                        n_mode = M_CODE;
                        n_star = 1'b0;
                    end else begin
                        n_star = (c == CH_STAR);
                    end
                end
            end
            M_QUOTE: begin
                if (r_esc) begin
                    n_esc = 1'b0;
                end else if (c == CH_BSLASH && !last) begin
                    n_esc = 1'b1;
                end else if (c == (r_qsingle ? CH_SQUOTE : CH_DQUOTE)) begin
                    n_mode = M_CODE;
                end
            end
            default: ;
        endcase

        // end of source returns everything to reset
        if (last) begin
            n_mode    = M_CODE;
            n_qsingle = 1'b0;
            n_esc     = 1'b0;
            n_slash   = 1'b0;
            n_star    = 1'b0;
        end
    end

    assign o_push = accept && emit;
    assign o_rec  = rec;

    // Lexer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= M_CODE;
            r_qsingle <= 1'b0;
            r_esc     <= 1'b0;
            r_slash   <= 1'b0;
            r_star    <= 1'b0;
        end else if (accept) begin
            r_mode    <= n_mode;
            r_qsingle <= n_qsingle;
            r_esc     <= n_esc;
            r_slash   <= n_slash;
            r_star    <= n_star;
        end
    end

    // A held slash only exists in code mode
    a_slash_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slash |-> (r_mode == M_CODE))
        else $error("slash held outside code");

    // A held star only exists in a block comment
    a_star_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_star |-> (r_mode == M_BLOCK))
        else $error("star held outside block comment");

    // Every accepted end-of-source item yields a record
    a_last_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && last) |-> o_push)
        else $error("end of source gave no record");

endmodule

// ===== src/cbl_queue.sv =====
// ----------------------------------------------------------------------------
// cbl_queue
// Small record FIFO between the lexer front end and the output stage.
// ----------------------------------------------------------------------------
module cbl_queue
    import cbl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_rec i_rec,
    input  logic i_pop,
    output t_rec o_rec,
    output logic o_empty,
    output logic o_full
);

    t_rec             r_mem [QDEPTH];
    logic [QAW-1:0]   r_wr_ptr;
    logic [QAW-1:0]   r_rd_ptr;
    logic [QAW:0]     r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (QAW+1)'(QDEPTH));
    assign o_rec   = r_mem[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("pop from empty queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QAW+1)'(QDEPTH))
        else $error("fill count out of range");

endmodule

// ===== src/cbl_back.sv =====
// ----------------------------------------------------------------------------
// cbl_back
// Output stage: drains records, sends one or two bytes per record through
// a registered output with run_last and stream_done marks.
// ----------------------------------------------------------------------------
module cbl_back
    import cbl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_rec      i_rec,
    input  logic      i_empty,
    output logic      o_pop,
    cbl_out_if.source o_out
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_run_last;
    logic       r_done;
    logic       r_sub;     // first byte of a two-byte record already sent

    logic load;
    logic first_of_two;

    assign load         = !i_empty && (!r_valid || o_out.ready);
    assign first_of_two = i_rec.two_res && !r_sub;
    assign o_pop        = load && !first_of_two;

    assign o_out.valid       = r_valid;
    assign o_out.out_byte    = r_byte;
    assign o_out.run_last    = r_run_last;
    assign o_out.stream_done = r_done;

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_sub   <= first_of_two;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            if (first_of_two) begin
                r_byte     <= i_rec.b0;
                r_run_last <= 1'b0;
                r_done     <= 1'b0;
            end else begin
                r_byte     <= r_sub ? i_rec.b1 : i_rec.b0;
                r_run_last <= 1'b1;
                r_done     <= i_rec.last;
            end
        end
    end

    // Mid-record: the record must still be at the head
    a_sub_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sub |-> (!i_empty && i_rec.two_res))
        else $error("second byte pending without two-byte record");

    a_sub_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sub |-> r_valid)
        else $error("second byte pending with idle output");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_done) |-> r_run_last)
        else $error("stream end not on an item's last byte");

endmodule

// ===== src/c_comment_blanker_unit.sv =====
// ----------------------------------------------------------------------------
// c_comment_blanker_unit
// Blanks C/C++ comments to spaces, keeping newlines and literals intact.
// ----------------------------------------------------------------------------
// Path: an accepted byte's record enters the queue, then the output register.
// Throughput: one source byte per clock while the queue has room; an item of
//   two bytes holds the single output register, absorbed by a 4-entry queue.
// A held slash gives no output until the next byte arrives.
// Reset: synchronous, clears lexer state, queue and output; no clear pass.
// ----------------------------------------------------------------------------
module c_comment_blanker_unit
    import cbl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    cbl_in_if.sink    i_in,
    cbl_out_if.source o_out
);

    logic push;
    logic pop;
    logic full;
    logic empty;
    t_rec rec_in;
    t_rec rec_head;

    cbl_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_rec   (rec_in)
    );

    cbl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (rec_in),
        .i_pop   (pop),
        .o_rec   (rec_head),
        .o_empty (empty),
        .o_full  (full)
    );

    cbl_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rec   (rec_head),
        .i_empty (empty),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

// ===== test/tb_c_comment_blanker_unit.sv =====
// ----------------------------------------------------------------------------
// tb_c_comment_blanker_unit
// Self-checking bench for the comment blanker. Source bytes are fed over the
// input channel from a queue of pending items; every accepted byte runs
// through a behavioral lexer kept here, and each blanked byte that comes out
// is checked field by field against the oldest predicted byte. Directed
// sources cover the corner cases, then random sources built from code,
// comments, literals and noise. Both channels idle in random bursts, except
// in the closing stretch.
// ----------------------------------------------------------------------------
module tb_c_comment_blanker_unit;
    import cbl_pkg::*;

    // Lexer modes of the behavioral copy
    typedef enum logic [1:0] {
        LX_CODE  = 2'd0,
        LX_LINE  = 2'd1,
        LX_BLOCK = 2'd2,
        LX_QUOTE = 2'd3
    } t_lex;

    // One pending source byte with its pacing
    typedef struct {
        bit [7:0]    ch;
        bit          fin;
        int unsigned gap;     // idle cycles before this item
        bit          drain;   // hold until all blanked bytes are out
        bit          calm;    // closing stretch, no idling
    } t_src_item;

    // One predicted blanked byte
    typedef struct packed {
        bit [7:0] ch;
        bit       run_last;
        bit       stream_done;
    } t_blank;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    cbl_in_if  src_ch();
    cbl_out_if blk_ch();

    c_comment_blanker_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (src_ch),
        .o_out   (blk_ch)
    );

    // Clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_src_item   feed_q[$];
    t_blank      blank_due[$];
    bit [7:0]    step_bytes[$];
    bit [7:0]    draft[$];
    int unsigned n_errors    = 0;
    int unsigned n_results   = 0;
    int unsigned n_queued    = 0;

    // Lexer copy
    t_lex lx_mode   = LX_CODE;
    bit   lx_single = 1'b0;
    bit   lx_esc    = 1'b0;
    bit   lx_slash  = 1'b0;
    bit   lx_star   = 1'b0;

    task automatic report_mismatch(input string msg);
        if (n_errors < 50)
            $display("MISMATCH @%0t: %s", $time, msg);
        n_errors++;
    endtask

    // Append one predicted byte for the current step
    function automatic void add_step(input bit [7:0] c);
        step_bytes = {step_bytes, c};
    endfunction

    // Append one byte to the draft source
    function automatic void add_draft(input bit [7:0] c);
        draft = {draft, c};
    endfunction

    // Code byte with no slash pending: a quote opens a literal
    function automatic void code_plain(input bit [7:0] c);
        if (c == CH_DQUOTE || c == CH_SQUOTE) begin
            lx_mode   = LX_QUOTE;
            lx_single = (c == CH_SQUOTE);
            lx_esc    = 1'b0;
        end
        add_step(c);
    endfunction

    // Blanked bytes caused by one accepted source byte
    task automatic predict_blank(input bit [7:0] c, input bit fin);
        t_blank r;
        step_bytes.delete();
        case (lx_mode)
            LX_CODE: begin
                if (lx_slash) begin
                    lx_slash = 1'b0;
                    if (c == CH_SLASH) begin
                        add_step(CH_SPACE);
                        add_step(CH_SPACE);
                        lx_mode = LX_LINE;
                    end else if (c == CH_STAR) begin
                        add_step(CH_SPACE);
                        add_step(CH_SPACE);
                        lx_mode = LX_BLOCK;
                        lx_star = 1'b0;
                    end else begin
                        add_step(CH_SLASH);
                        code_plain(c);
                    end
                end else if (c == CH_SLASH) begin
                    // slash at end of source goes out as itself
                    if (fin)
                        add_step(CH_SLASH);
                    else
                        lx_slash = 1'b1;
                end else begin
                    code_plain(c);
                end
            end
            LX_LINE: begin
                if (c == CH_NL) begin
                    add_step(CH_NL);
                    lx_mode = LX_CODE;
                end else begin
                    add_step(CH_SPACE);
                end
            end
            LX_BLOCK: begin
                if (c == CH_NL) begin
                    add_step(CH_NL);
                    lx_star = 1'b0;
                end else begin
                    add_step(CH_SPACE);
                    if (lx_star && c == CH_SLASH) begin
                        lx_mode = LX_CODE;
                        lx_star = 1'b0;
                    end else begin
                        lx_star = (c == CH_STAR);
                    end
                end
            end
            default: begin
                add_step(c);
                if (lx_esc)
                    lx_esc = 1'b0;
                else if (c == CH_BSLASH && !fin)
                    lx_esc = 1'b1;
                else if (c == (lx_single ? CH_SQUOTE : CH_DQUOTE))
                    lx_mode = LX_CODE;
            end
        endcase
        foreach (step_bytes[k]) begin
            r.ch          = step_bytes[k];
            r.run_last    = (k == step_bytes.size() - 1);
            r.stream_done = fin && (k == step_bytes.size() - 1);
            blank_due     = {blank_due, r};
        end
        // end of source: back to reset state
        if (fin) begin
            lx_mode   = LX_CODE;
            lx_single = 1'b0;
            lx_esc    = 1'b0;
            lx_slash  = 1'b0;
            lx_star   = 1'b0;
        end
    endtask

    // Monitor: input acceptance feeds the lexer copy, output is checked
    bit in_fire = 1'b0;
    always @(posedge i_clk) begin
        t_blank want;
        in_fire = i_rst_n && src_ch.valid && src_ch.ready;
        if (in_fire)
            predict_blank(src_ch.in_byte, src_ch.source_end);
        if (i_rst_n && blk_ch.valid && blk_ch.ready) begin
            if (blank_due.size() == 0) begin
                report_mismatch($sformatf("result %0d (byte %h) with nothing pending",
                                          n_results, blk_ch.out_byte));
            end else begin
                want = blank_due.pop_front();
                if (blk_ch.out_byte !== want.ch)
                    report_mismatch($sformatf("result %0d: out_byte %h, want %h",
                                              n_results, blk_ch.out_byte, want.ch));
                if (blk_ch.run_last !== want.run_last)
                    report_mismatch($sformatf("result %0d: run_last %b, want %b",
                                              n_results, blk_ch.run_last, want.run_last));
                if (blk_ch.stream_done !== want.stream_done)
                    report_mismatch($sformatf("result %0d: stream_done %b, want %b",
                                              n_results, blk_ch.stream_done,
                                              want.stream_done));
            end
            n_results++;
        end
    end

    // Driver: presents pending items, honoring gaps and drain holds
    t_src_item   cur;
    bit          cur_on    = 1'b0;
    bit          shown     = 1'b0;
    bit          tail_calm = 1'b0;
    int unsigned gap_left  = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            src_ch.valid <= 1'b0;
        end else begin
            if (in_fire) begin
                cur_on = 1'b0;
                shown  = 1'b0;
            end
            if (!cur_on && feed_q.size() != 0) begin
                cur      = feed_q.pop_front();
                cur_on   = 1'b1;
                shown    = 1'b0;
                gap_left = cur.gap;
                if (cur.calm)
                    tail_calm = 1'b1;
            end
            if (cur_on && !shown) begin
                if (gap_left != 0)
                    gap_left--;
                else if (!cur.drain || blank_due.size() == 0)
                    shown = 1'b1;
            end
            src_ch.valid      <= cur_on && shown;
            src_ch.in_byte    <= cur.ch;
            src_ch.source_end <= cur.fin;
        end
    end

    // Receiver: random stall bursts, quiet stretches, none at the tail
    int unsigned stall_left = 0;
    bit          sink_quiet = 1'b0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            blk_ch.ready <= 1'b0;
        end else if (tail_calm) begin
            blk_ch.ready <= 1'b1;
        end else begin
            if ($urandom_range(0, 299) == 0)
                sink_quiet = !sink_quiet;
            if (stall_left != 0) begin
                stall_left--;
                blk_ch.ready <= 1'b0;
            end else if (!sink_quiet && $urandom_range(0, 99) < 10) begin
                stall_left = $urandom_range(0, 17);
                blk_ch.ready <= 1'b0;
            end else begin
                blk_ch.ready <= 1'b1;
            end
        end
    end

    // Move the draft source into the pending queue, last byte closes it
    task automatic queue_source(input int unsigned gap_pct, input bit calm,
                                input bit drain_first);
        t_src_item it;
        foreach (draft[k]) begin
            it.ch    = draft[k];
            it.fin   = (k == draft.size() - 1);
            it.gap   = (!calm && $urandom_range(0, 99) < gap_pct) ?
                       $urandom_range(1, 18) : 0;
            it.drain = drain_first && (k == 0);
            it.calm  = calm;
            feed_q   = {feed_q, it};
        end
        n_queued += draft.size();
        draft.delete();
    endtask

    // Random byte biased toward lexer-relevant characters
    function automatic bit [7:0] filler();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)      return 8'($urandom_range(8'h61, 8'h7A));
        else if (r < 63) return CH_SPACE;
        else if (r < 71) return CH_STAR;
        else if (r < 79) return CH_SLASH;
        else if (r < 84) return CH_NL;
        else if (r < 87) return CH_DQUOTE;
        else if (r < 90) return CH_SQUOTE;
        else if (r < 93) return CH_BSLASH;
        else             return 8'($urandom_range(0, 255));
    endfunction

    // Append one token of C-like text to the draft
    task automatic add_token();
        case ($urandom_range(0, 9))
            0, 1, 2: repeat ($urandom_range(1, 6)) add_draft(filler());
            3: begin
                add_draft(CH_SLASH);
                add_draft(CH_SLASH);
                repeat ($urandom_range(0, 8)) add_draft(filler());
                add_draft(CH_NL);
            end
            4: begin
                add_draft(CH_SLASH);
                add_draft(CH_STAR);
                repeat ($urandom_range(0, 10)) add_draft(filler());
                add_draft(CH_STAR);
                add_draft(CH_SLASH);
            end
            5: begin
                add_draft(CH_DQUOTE);
                repeat ($urandom_range(0, 8)) begin
                    if ($urandom_range(0, 4) == 0)
                        add_draft(CH_BSLASH);
                    add_draft(filler());
                end
                add_draft(CH_DQUOTE);
            end
            6: begin
                add_draft(CH_SQUOTE);
                if ($urandom_range(0, 2) == 0)
                    add_draft(CH_BSLASH);
                add_draft(filler());
                add_draft(CH_SQUOTE);
            end
            7: add_draft(CH_NL);
            8: add_draft(8'($urandom_range(0, 255)));
            default: begin
                add_draft(CH_SLASH);
                add_draft(filler());
            end
        endcase
    endtask

    // Stimulus and end of run
    initial begin
        int unsigned target;
        int unsigned pct;
        bit          first_rand;
        src_ch.valid      = 1'b0;
        src_ch.in_byte    = 8'h00;
        src_ch.source_end = 1'b0;
        blk_ch.ready      = 1'b0;
        first_rand        = 1'b1;

        // code with 00/FF, held slash, line comment, block open/close,
        // slash right after the opening, newline clearing a held star
        draft = {8'h00, CH_SLASH, 8'h62, CH_SLASH, CH_SLASH, 8'h71, CH_NL,
                 CH_SLASH, CH_STAR, CH_SLASH, CH_STAR, CH_NL, CH_STAR, CH_SLASH,
                 8'hFF};
        queue_source(30, 1'b0, 1'b0);
        // char literal with escape, string ending on a trailing backslash
        draft = {CH_SQUOTE, CH_BSLASH, CH_SQUOTE, CH_SQUOTE, CH_DQUOTE, CH_BSLASH};
        queue_source(30, 1'b0, 1'b0);
        // lone slash as the whole source
        draft = {CH_SLASH};
        queue_source(30, 1'b0, 1'b0);
        // open string across a newline, slash closing the source
        draft = {CH_DQUOTE, CH_NL, CH_SLASH};
        queue_source(30, 1'b0, 1'b0);

        // random sources
        while (n_queued < 1525) begin
            target = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) :
                     $urandom_range(4, 48);
            while (draft.size() < target)
                add_token();
            case ($urandom_range(0, 4))
                0, 1:    pct = 0;
                2:       pct = 10;
                3:       pct = 25;
                default: pct = 40;
            endcase
            queue_source(pct, n_queued >= 1300,
                         first_rand || $urandom_range(0, 14) == 0);
            first_rand = 1'b0;
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (feed_q.size() != 0 || cur_on || blank_due.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (n_errors == 0 && blank_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog
    initial begin
        #4000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
